// ===== hdl/sbef_pkg.sv =====
// shared types and constants of the stretch bond energy and force unit
package sbef_pkg;

  localparam int unsigned NumStages = 42;
  localparam logic [39:0] EnergyMax = 40'hFF_FFFF_FFFF;
  localparam logic [27:0] Ln2Q28 = 28'hB17217F;
  localparam logic [31:0] CubeRoot2Frac = 32'h428A2F99;
  localparam logic [55:0] HalfQ32 = 56'h80000000;

  typedef enum logic [1:0] {
    KindHarmonic = 2'd0,
    KindFene     = 2'd1,
    KindFeneWca  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StBeyond = 2'd1,
    StZero   = 2'd2,
    StSat    = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    RegKind    = 3'd0,
    RegHalfK   = 3'd1,
    RegRest    = 3'd2,
    RegLimitSq = 3'd3,
    RegWcaEps  = 3'd4,
    RegWcaSize = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] half_k;
    logic [30:0] rest;
    logic [47:0] limit_sq;
    logic [31:0] eps;
    logic [47:0] size_sq;
  } cfg_t;

  typedef struct packed {
    logic [2:0]        neg;
    logic [2:0][31:0]  mag;
    logic [2:0][63:0]  sq;
    logic [63:0]       r2;
    // harmonic
    logic [33:0]       sq_rem;
    logic [31:0]       root;
    logic              rzero;
    logic              dneg;
    logic [31:0]       ad;
    logic [63:0]       ad2;
    logic [63:0]       hsad;
    logic [63:0]       ehl;
    logic [63:0]       ehh;
    logic [48:0]       fm;
    logic [39:0]       eh;
    logic              eh_sat;
    logic [2:0][32:0]  dv_rem;
    logic [2:0][30:0]  u;
    logic [2:0][62:0]  fpl;
    logic [2:0][47:0]  fph;
    logic [2:0][31:0]  force_v;
    logic              f_sat;
    // fene
    logic              beyond;
    logic              wzero;
    logic [1:0][63:0]  lnv;
    logic [1:0][5:0]   le;
    logic [1:0][31:0]  lm;
    logic [1:0][29:0]  lf;
    logic [35:0]       dl;
    logic [35:0]       nl;
    logic [37:0]       tt;
    logic [61:0]       efl;
    logic [61:0]       efh;
    logic [39:0]       ef;
    logic              ef_sat;
    // wca
    logic [55:0]       tpl;
    logic [55:0]       tph;
    logic              w_apply;
    logic              w_big;
    logic [64:0]       wrem;
    logic [39:0]       ws;
    logic [71:0]       ssl;
    logic [47:0]       ssh;
    logic [47:0]       s2;
    logic [63:0]       s3l;
    logic [63:0]       s3h;
    logic [55:0]       vv;
    logic [63:0]       vll;
    logic [55:0]       vlh;
    logic [47:0]       vhh;
    logic [63:0]       qq;
    logic              q_ov;
    logic [63:0]       eql;
    logic [63:0]       eqh;
    logic [39:0]       ew;
    logic              ew_sat;
    // result
    logic [39:0]       energy;
    logic              fvalid;
    logic [1:0]        status;
  } pipe_t;

endpackage

// ===== hdl/stretch_bond_energy_force_unit.sv =====
// top level of the stretch bond energy and force unit
// throughput: one beat per cycle; the whole pipeline holds while a result beat waits
// the sqrt, divider and log2 squaring chains are spread one or two steps per stage
// reset clears the configuration registers to zero and empties the pipeline
module stretch_bond_energy_force_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [5:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // dist_x, dist_y, dist_z
  input  logic [95:0]   s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // energy, force_x, force_y, force_z
  output logic [135:0]  m_axis_tdata,
  // force_valid, status
  output logic [2:0]    m_axis_tuser
);

  sbef_pkg::cfg_t  cfg_q;
  sbef_pkg::pipe_t pipe_in [0:sbef_pkg::NumStages-1];
  sbef_pkg::pipe_t pipe_d  [0:sbef_pkg::NumStages-1];
  sbef_pkg::pipe_t pipe_q  [1:sbef_pkg::NumStages];
  logic [sbef_pkg::NumStages:1] vld_q;
  logic en;

  function automatic sbef_pkg::pipe_t sbef_step(input int unsigned k,
                                                input sbef_pkg::pipe_t x,
                                                input sbef_pkg::cfg_t c);
    sbef_pkg::pipe_t y;
    int unsigned s, j, w;
    logic [35:0]  sh36;
    logic [35:0]  trial;
    logic [33:0]  d34;
    logic [65:0]  w66;
    logic [63:0]  p64;
    logic [63:0]  sig;
    logic [32:0]  p33;
    logic [80:0]  p81;
    logic [79:0]  p80;
    logic [85:0]  p86;
    logic [87:0]  p88;
    logic [95:0]  p96;
    logic [111:0] p112;
    logic [50:0]  f51;
    logic [50:0]  cap;
    logic [40:0]  sum41;
    logic [35:0]  la;
    logic [35:0]  lb;
    logic [55:0]  s3;
    logic         fneg;
    logic         b;
    y = x;
    sig = {c.size_sq, 16'h0};
    if (k == 0) begin
      for (int n = 0; n < 3; n++) y.sq[n] = 64'(x.mag[n]) * 64'(x.mag[n]);
    end
    if (k == 1) y.r2 = x.sq[0] + x.sq[1] + x.sq[2];
    // square root, two result bits per stage
    if (k >= 2 && k <= 17) begin
      for (int t = 0; t < 2; t++) begin
        s = 2 * (k - 2) + t;
        j = 31 - s;
        if (s == 0) begin
          y.sq_rem = '0;
          y.root = '0;
        end
        sh36 = {y.sq_rem, x.r2[2*j +: 2]};
        trial = {2'b00, y.root, 2'b01};
        if (sh36 >= trial) begin
          y.sq_rem = 34'(sh36 - trial);
          y.root = {y.root[30:0], 1'b1};
        end else begin
          y.sq_rem = sh36[33:0];
          y.root = {y.root[30:0], 1'b0};
        end
      end
    end
    if (k == 18) begin
      y.rzero = (x.root == 32'h0);
      y.dneg = (x.root > {1'b0, c.rest});
      y.ad = y.dneg ? x.root - {1'b0, c.rest} : {1'b0, c.rest} - x.root;
    end
    // unit vector dividers
    if (k >= 18 && k <= 33) begin
      for (int t = 0; t < 2; t++) begin
        s = 2 * (k - 18) + t;
        if (s < 31) begin
          for (int n = 0; n < 3; n++) begin
            if (s == 0) begin
              y.dv_rem[n] = 33'(x.mag[n] >> 1);
              y.u[n] = '0;
            end
            b = (s == 0) ? x.mag[n][0] : 1'b0;
            d34 = {y.dv_rem[n], b};
            if (d34 >= {2'b00, x.root}) begin
              y.dv_rem[n] = 33'(d34 - {2'b00, x.root});
              y.u[n] = {y.u[n][29:0], 1'b1};
            end else begin
              y.dv_rem[n] = d34[32:0];
              y.u[n] = {y.u[n][29:0], 1'b0};
            end
          end
        end
      end
    end
    if (k == 19) begin
      y.ad2 = 64'(x.ad) * 64'(x.ad);
      y.hsad = 64'(c.half_k) * 64'(x.ad);
    end
    if (k == 20) begin
      y.ehl = 64'(c.half_k) * 64'(x.ad2[31:0]);
      y.ehh = 64'(c.half_k) * 64'(x.ad2[63:32]);
      y.fm = x.hsad[63:15];
    end
    if (k == 21) begin
      p96 = {32'h0, x.ehl} + {x.ehh, 32'h0};
      y.eh_sat = |p96[95:72];
      y.eh = y.eh_sat ? sbef_pkg::EnergyMax : p96[71:32];
    end
    if (k == 34) begin
      for (int n = 0; n < 3; n++) begin
        y.fpl[n] = 63'(x.fm[31:0]) * 63'(x.u[n]);
        y.fph[n] = 48'(x.fm[48:32]) * 48'(x.u[n]);
      end
    end
    if (k == 35) begin
      y.f_sat = 1'b0;
      for (int n = 0; n < 3; n++) begin
        p81 = 81'(x.fpl[n]) + {1'b0, x.fph[n], 32'h0};
        f51 = p81[80:30];
        fneg = (x.dneg != x.neg[n]) && (f51 != '0);
        cap = fneg ? 51'h80000000 : 51'h7FFFFFFF;
        if (f51 > cap) begin
          f51 = cap;
          y.f_sat = 1'b1;
        end
        y.force_v[n] = fneg ? 32'(-f51[31:0]) : f51[31:0];
      end
    end
    // fene log2 front and fene energy (stage 2 also prepares the wca threshold terms)
    if (k == 2) begin
      p64 = {c.limit_sq, 16'h0};
      y.beyond = c.kind[1] ? (x.r2 > p64) : (x.r2 >= p64);
      y.wzero = (x.r2 == 64'h0);
      y.lnv[0] = p64;
      y.lnv[1] = p64 - x.r2;
      y.le[0] = 6'd63;
      y.le[1] = 6'd63;
      y.tpl = 56'(c.size_sq[23:0]) * 56'(sbef_pkg::CubeRoot2Frac);
      y.tph = 56'(c.size_sq[47:24]) * 56'(sbef_pkg::CubeRoot2Frac);
      y.w_big = (x.r2 < 64'h0100_0000_0000_0000) && ({8'h0, sig} >= {x.r2, 8'h0});
    end
    if (k >= 3 && k <= 5) begin
      for (int t = 0; t < 2; t++) begin
        w = 32 >> (2 * (k - 3) + t);
        for (int l = 0; l < 2; l++) begin
          if ((y.lnv[l] >> (64 - w)) == 64'h0) begin
            y.lnv[l] = y.lnv[l] << w;
            y.le[l] = y.le[l] - 6'(w);
          end
        end
      end
      if (k == 5) begin
        for (int l = 0; l < 2; l++) begin
          y.lm[l] = y.lnv[l][63:32];
          y.lf[l] = '0;
        end
      end
    end
    if (k >= 6 && k <= 35) begin
      for (int l = 0; l < 2; l++) begin
        p64 = 64'(x.lm[l]) * 64'(x.lm[l]);
        p33 = p64[63:31];
        y.lm[l] = p33[32] ? p33[32:1] : p33[31:0];
        y.lf[l] = {x.lf[l][28:0], p33[32]};
      end
    end
    if (k == 36) begin
      la = {x.le[0], x.lf[0]};
      lb = {x.le[1], x.lf[1]};
      y.dl = (la > lb) ? la - lb : 36'h0;
    end
    if (k == 37) begin
      p64 = 64'(x.dl) * 64'(sbef_pkg::Ln2Q28);
      y.nl = p64[63:28];
    end
    if (k == 38) begin
      p80 = 80'(c.half_k) * 80'(x.nl);
      y.tt = p80[67:30];
    end
    if (k == 39) begin
      y.efl = 62'(x.tt) * 62'(c.limit_sq[23:0]);
      y.efh = 62'(x.tt) * 62'(c.limit_sq[47:24]);
    end
    if (k == 40) begin
      p86 = {24'h0, x.efl} + {x.efh, 24'h0};
      y.ef_sat = |p86[85:56];
      y.ef = p86[55:16];
    end
    // wca
    if (k == 3) begin
      p81 = 81'(x.tpl) + (81'(x.tph) << 24) + {1'b0, c.size_sq, 32'h0};
      y.w_apply = c.kind[1] && (c.eps != 32'h0) && (p81[80] || (x.r2 <= p81[79:16]));
    end
    if (k >= 2 && k <= 21) begin
      for (int t = 0; t < 2; t++) begin
        s = 2 * (k - 2) + t;
        if (s == 0) begin
          y.wrem = 65'(sig >> 8);
          y.ws = '0;
        end
        b = (s < 8) ? sig[7 - s] : 1'b0;
        w66 = {y.wrem, b};
        if (w66 >= 66'(x.r2)) begin
          y.wrem = 65'(w66 - 66'(x.r2));
          y.ws = {y.ws[38:0], 1'b1};
        end else begin
          y.wrem = w66[64:0];
          y.ws = {y.ws[38:0], 1'b0};
        end
      end
    end
    if (k == 22) begin
      y.ssl = 72'(x.ws[31:0]) * 72'(x.ws);
      y.ssh = 48'(x.ws[39:32]) * 48'(x.ws);
    end
    if (k == 23) begin
      p80 = {8'h0, x.ssl} + {x.ssh, 32'h0};
      y.s2 = p80[79:32];
    end
    if (k == 24) begin
      y.s3l = 64'(x.s2[23:0]) * 64'(x.ws);
      y.s3h = 64'(x.s2[47:24]) * 64'(x.ws);
    end
    if (k == 25) begin
      p88 = {24'h0, x.s3l} + {x.s3h, 24'h0};
      s3 = p88[87:32];
      y.vv = (s3 > sbef_pkg::HalfQ32) ? s3 - sbef_pkg::HalfQ32 : sbef_pkg::HalfQ32 - s3;
    end
    if (k == 26) begin
      y.vll = 64'(x.vv[31:0]) * 64'(x.vv[31:0]);
      y.vlh = 56'(x.vv[31:0]) * 56'(x.vv[55:32]);
      y.vhh = 48'(x.vv[55:32]) * 48'(x.vv[55:32]);
    end
    if (k == 27) begin
      p112 = 112'(x.vll) + (112'(x.vlh) << 33) + (112'(x.vhh) << 64);
      y.q_ov = |p112[111:96];
      y.qq = p112[95:32];
    end
    if (k == 28) begin
      y.eql = 64'(c.eps) * 64'(x.qq[31:0]);
      y.eqh = 64'(c.eps) * 64'(x.qq[63:32]);
    end
    if (k == 29) begin
      p96 = {32'h0, x.eql} + {x.eqh, 32'h0};
      y.ew_sat = x.q_ov || (|p96[95:72]);
      y.ew = p96[71:32];
    end
    // result select
    if (k == 41) begin
      if (c.kind == sbef_pkg::KindHarmonic) begin
        y.energy = x.eh;
        if (x.rzero) begin
          y.force_v = '0;
          y.fvalid = 1'b0;
          y.status = sbef_pkg::StZero;
        end else begin
          y.fvalid = 1'b1;
          y.status = (x.eh_sat || x.f_sat) ? sbef_pkg::StSat : sbef_pkg::StOk;
        end
      end else begin
        y.force_v = '0;
        y.fvalid = 1'b0;
        if (x.beyond) begin
          y.energy = sbef_pkg::EnergyMax;
          y.status = sbef_pkg::StBeyond;
        end else if (c.kind[1] && x.wzero) begin
          y.energy = '0;
          y.status = sbef_pkg::StZero;
        end else if (x.ef_sat || (x.w_apply && (x.w_big || x.ew_sat))) begin
          y.energy = sbef_pkg::EnergyMax;
          y.status = sbef_pkg::StSat;
        end else begin
          sum41 = {1'b0, x.ef} + (x.w_apply ? {1'b0, x.ew} : 41'h0);
          y.energy = sum41[40] ? sbef_pkg::EnergyMax : sum41[39:0];
          y.status = sum41[40] ? sbef_pkg::StSat : sbef_pkg::StOk;
        end
      end
    end
    return y;
  endfunction

  // configuration
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (sbef_pkg::reg_idx_e'(paddr[5:3]))
        sbef_pkg::RegKind:    cfg_q.kind     <= pwdata[1:0];
        sbef_pkg::RegHalfK:   cfg_q.half_k   <= pwdata[31:0];
        sbef_pkg::RegRest:    cfg_q.rest     <= pwdata[30:0];
        sbef_pkg::RegLimitSq: cfg_q.limit_sq <= pwdata[47:0];
        sbef_pkg::RegWcaEps:  cfg_q.eps      <= pwdata[31:0];
        sbef_pkg::RegWcaSize: cfg_q.size_sq  <= pwdata[47:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sbef_pkg::reg_idx_e'(paddr[5:3]))
      sbef_pkg::RegKind:    prdata = 64'(cfg_q.kind);
      sbef_pkg::RegHalfK:   prdata = 64'(cfg_q.half_k);
      sbef_pkg::RegRest:    prdata = 64'(cfg_q.rest);
      sbef_pkg::RegLimitSq: prdata = 64'(cfg_q.limit_sq);
      sbef_pkg::RegWcaEps:  prdata = 64'(cfg_q.eps);
      sbef_pkg::RegWcaSize: prdata = 64'(cfg_q.size_sq);
      default:              prdata = 64'h0;
    endcase
  end

  // pipeline
  assign en = !vld_q[sbef_pkg::NumStages] || m_axis_tready;
  assign s_axis_tready = en;

  always_comb begin
    pipe_in[0] = '0;
    for (int n = 0; n < 3; n++) begin
      pipe_in[0].neg[n] = s_axis_tdata[32*n+31];
      pipe_in[0].mag[n] = s_axis_tdata[32*n+31] ? 32'(-s_axis_tdata[32*n +: 32])
                                                 : s_axis_tdata[32*n +: 32];
    end
  end

  for (genvar g = 0; g < sbef_pkg::NumStages; g++) begin : g_stage
    if (g > 0) begin : g_link
      assign pipe_in[g] = pipe_q[g];
    end
    always_comb pipe_d[g] = sbef_step(g, pipe_in[g], cfg_q);
    always_ff @(posedge clk_i) begin
      if (en) pipe_q[g+1] <= pipe_d[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[sbef_pkg::NumStages-1:1], s_axis_tvalid};
    end
  end

  assign m_axis_tvalid = vld_q[sbef_pkg::NumStages];
  assign m_axis_tdata = {pipe_q[sbef_pkg::NumStages].force_v[2],
                         pipe_q[sbef_pkg::NumStages].force_v[1],
                         pipe_q[sbef_pkg::NumStages].force_v[0],
                         pipe_q[sbef_pkg::NumStages].energy};
  assign m_axis_tuser = {pipe_q[sbef_pkg::NumStages].status,
                         pipe_q[sbef_pkg::NumStages].fvalid};

endmodule

// ===== sim/tb.sv =====
// testbench of the stretch bond energy and force unit: bit-exact predictor with random idling
`timescale 1ns / 100ps

module tb;

  typedef struct {
    logic [39:0] energy;
    logic [31:0] fx, fy, fz;
    logic        fvalid;
    logic [1:0]  status;
  } bond_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]   paddr = '0;
  logic [63:0]  pwdata = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [135:0] m_axis_tdata;
  logic [2:0]   m_axis_tuser;

  int  n_errors = 0;
  int  n_results = 0;
  int  n_phases = 0;
  int  quiet_cycles = 0;
  bit  no_idle = 1'b0;
  bit  running = 1'b0;
  int  out_stall = 0;

  stretch_bond_energy_force_unit dut (.*);

  always #5 clk_i = ~clk_i;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    n_errors++;
    $display("mismatch %s: got %0h expected %0h (result %0d)", what, got, want, n_results);
  endtask

  class bond_scoreboard;
    bit [1:0]  kind;
    bit [31:0] half_k;
    bit [30:0] rest;
    bit [47:0] limit_sq;
    bit [31:0] eps;
    bit [47:0] size_sq;
    bond_res_t pending_q[$];

    function void set_reg(sbef_pkg::reg_idx_e idx, bit [63:0] v);
      case (idx)
        sbef_pkg::RegKind:    kind = v[1:0];
        sbef_pkg::RegHalfK:   half_k = v[31:0];
        sbef_pkg::RegRest:    rest = v[30:0];
        sbef_pkg::RegLimitSq: limit_sq = v[47:0];
        sbef_pkg::RegWcaEps:  eps = v[31:0];
        sbef_pkg::RegWcaSize: size_sq = v[47:0];
        default: ;
      endcase
    endfunction

    function bit [63:0] mul_shr(bit [63:0] a, bit [63:0] b, int unsigned s, inout bit ovf);
      bit [127:0] p;
      p = ({64'b0, a} * {64'b0, b}) >> s;
      if (p[127:64] != 0) ovf = 1'b1;
      return p[63:0];
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] v);
      bit [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function bit [63:0] log2_q30(bit [63:0] v);
      int e;
      bit [63:0] m, frac;
      e = 63;
      frac = 0;
      while (e > 0 && v[e] == 1'b0) e--;
      m = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
      for (int i = 0; i < 30; i++) begin
        m = (m * m) >> 31;
        frac <<= 1;
        if (m >= (64'd1 << 32)) begin
          m >>= 1;
          frac |= 1;
        end
      end
      return (64'(e) << 30) | frac;
    endfunction

    function bond_res_t bond_energy(bit [31:0] d [3]);
      bond_res_t res;
      bit [63:0] mag [3];
      bit        neg [3];
      bit [63:0] r2, energy, r, ad, fm, u, f, cap, big_r2, la, lb, dl, nl, t, ef, ew;
      bit [63:0] thr, sig, s, s2, s3, dv, q, force_v [3];
      bit        sat, fvalid, ov, dneg, fneg, wca_mode, beyond, wov, qov;
      bit [1:0]  status;
      r2 = 0; energy = 0; sat = 0; fvalid = 0; status = sbef_pkg::StOk; ov = 0;
      force_v = '{0, 0, 0};
      for (int i = 0; i < 3; i++) begin
        neg[i] = d[i][31];
        mag[i] = neg[i] ? 64'(32'(-d[i])) : 64'(d[i]);
        r2 += mag[i] * mag[i];
      end
      if (kind == sbef_pkg::KindHarmonic) begin
        r = floor_sqrt(r2);
        dneg = r > rest;
        ad = dneg ? r - rest : rest - r;
        energy = mul_shr(64'(half_k), ad * ad, 32, ov);
        if (energy > sbef_pkg::EnergyMax) begin
          energy = sbef_pkg::EnergyMax;
          sat = 1;
        end
        if (r == 0) begin
          status = sbef_pkg::StZero;
        end else begin
          fm = mul_shr(64'(half_k), ad, 15, ov);
          fvalid = 1;
          for (int i = 0; i < 3; i++) begin
            u = (mag[i] << 30) / r;
            f = mul_shr(fm, u, 30, ov);
            fneg = (dneg != neg[i]) && f != 0;
            cap = fneg ? (64'd1 << 31) : 64'h7FFF_FFFF;
            if (f > cap) begin
              f = cap;
              sat = 1;
            end
            force_v[i] = fneg ? ((~f + 1) & 64'hFFFF_FFFF) : f;
          end
        end
      end else begin
        big_r2 = 64'(limit_sq) << 16;
        wca_mode = kind[1];
        beyond = wca_mode ? (r2 > big_r2) : (r2 >= big_r2);
        if (beyond) begin
          status = sbef_pkg::StBeyond;
          energy = sbef_pkg::EnergyMax;
        end else if (wca_mode && r2 == 0) begin
          status = sbef_pkg::StZero;
          energy = 0;
        end else begin
          la = log2_q30(big_r2);
          lb = log2_q30(big_r2 - r2);
          dl = la > lb ? la - lb : 0;
          nl = (dl * 64'(sbef_pkg::Ln2Q28)) >> 28;
          t = mul_shr(64'(half_k), nl, 30, ov);
          ef = mul_shr(t, 64'(limit_sq), 16, ov);
          ew = 0;
          if (ov || ef > sbef_pkg::EnergyMax) sat = 1;
          if (wca_mode && eps != 0) begin
            wov = 0;
            thr = mul_shr(64'(size_sq), 64'h1_428A_2F99, 16, wov);
            if (wov || r2 <= thr) begin
              sig = 64'(size_sq) << 16;
              if (r2 < (64'd1 << 56) && sig >= (r2 << 8)) begin
                sat = 1;
              end else begin
                qov = 0;
                s = 64'(({64'b0, sig} << 32) / {64'b0, r2});
                s2 = mul_shr(s, s, 32, qov);
                s3 = mul_shr(s2, s, 32, qov);
                dv = s3 > 64'(sbef_pkg::HalfQ32) ? s3 - 64'(sbef_pkg::HalfQ32)
                                                 : 64'(sbef_pkg::HalfQ32) - s3;
                q = mul_shr(dv, dv, 32, qov);
                ew = mul_shr(64'(eps), q, 32, qov);
                if (qov || ew > sbef_pkg::EnergyMax) sat = 1;
              end
            end
          end
          if (sat) begin
            energy = sbef_pkg::EnergyMax;
          end else begin
            energy = ef + ew;
            if (energy > sbef_pkg::EnergyMax) begin
              energy = sbef_pkg::EnergyMax;
              sat = 1;
            end
          end
        end
      end
      if (status == sbef_pkg::StOk && sat) status = sbef_pkg::StSat;
      res.energy = energy[39:0];
      res.fx = force_v[0][31:0];
      res.fy = force_v[1][31:0];
      res.fz = force_v[2][31:0];
      res.fvalid = fvalid;
      res.status = status;
      return res;
    endfunction

    function void note_bond(bit [95:0] beat);
      bit [31:0] d [3];
      d[0] = beat[31:0];
      d[1] = beat[63:32];
      d[2] = beat[95:64];
      pending_q.push_back(bond_energy(d));
    endfunction

    task check_result(logic [135:0] data, logic [2:0] user);
      bond_res_t w;
      if (pending_q.size() == 0) begin
        report("unexpected beat", 64'(data[39:0]), 64'd0);
        return;
      end
      w = pending_q.pop_front();
      if (data[39:0] !== w.energy) report("energy", 64'(data[39:0]), 64'(w.energy));
      if (data[71:40] !== w.fx) report("force_x", 64'(data[71:40]), 64'(w.fx));
      if (data[103:72] !== w.fy) report("force_y", 64'(data[103:72]), 64'(w.fy));
      if (data[135:104] !== w.fz) report("force_z", 64'(data[135:104]), 64'(w.fz));
      if (user[0] !== w.fvalid) report("force_valid", 64'(user[0]), 64'(w.fvalid));
      if (user[2:1] !== w.status) report("status", 64'(user[2:1]), 64'(w.status));
    endtask
  endclass

  bond_scoreboard sb = new();

  // result side with random stalls
  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata, m_axis_tuser);
      n_results++;
      out_stall = no_idle ? 0 : $urandom_range(0, 9);
    end
    if (out_stall > 0) begin
      m_axis_tready <= 1'b0;
      out_stall--;
    end else begin
      m_axis_tready <= running;
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !running) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(sbef_pkg::reg_idx_e idx, bit [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 6'(8 * int'(idx));
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_reg(idx, v);
  endtask

  task automatic set_bond(bit [1:0] kind, bit [31:0] hk, bit [30:0] rl, bit [47:0] lim,
                          bit [31:0] ep, bit [47:0] sz);
    write_reg(sbef_pkg::RegKind, 64'(kind));
    write_reg(sbef_pkg::RegHalfK, 64'(hk));
    write_reg(sbef_pkg::RegRest, 64'(rl));
    write_reg(sbef_pkg::RegLimitSq, 64'(lim));
    write_reg(sbef_pkg::RegWcaEps, 64'(ep));
    write_reg(sbef_pkg::RegWcaSize, 64'(sz));
    n_phases++;
    no_idle = ($urandom_range(0, 3) == 0);
  endtask

  task automatic send_bond(bit [31:0] x, bit [31:0] y, bit [31:0] z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_bond(s_axis_tdata);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic bit [31:0] rand_comp(int e);
    bit [31:0] m;
    if ($urandom_range(0, 9) == 0) return $urandom;
    m = (e == 0) ? 32'd0 : ($urandom >> (32 - e));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic bit [47:0] scaled_sq(int e, int lo, int hi);
    bit [71:0] v;
    v = ((72'($urandom_range(lo, hi)) << (2 * e)) >> 16) + 72'($urandom_range(0, 3));
    return (v > 72'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : v[47:0];
  endfunction

  localparam bit [31:0] DMax = 32'h7FFF_FFFF;
  localparam bit [31:0] DMin = 32'h8000_0000;

  initial begin
    int e;
    bit [31:0] hk;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    running = 1'b1;

    set_bond(sbef_pkg::KindHarmonic, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '1, '1, '1);
    send_bond(0, 0, 0);
    send_bond(DMax, DMax, DMax);
    send_bond(DMin, DMin, DMin);
    send_bond(DMin, 0, 0);
    send_bond(1, 0, 0);
    send_bond(32'hFFFF_FFFF, 0, 0);
    send_bond(0, 0, DMax);
    send_bond(1, 32'hFFFF_FFFF, 1);
    drain();
    set_bond(sbef_pkg::KindFene, 32'h0001_0000, 0, 0, 0, 0);
    send_bond(0, 0, 0);
    send_bond(1, 0, 0);
    drain();
    set_bond(sbef_pkg::KindFene, 32'hFFFF_FFFF, 0, '1, 0, 0);
    send_bond(0, 0, 0);
    send_bond(DMax, 0, 0);
    send_bond(DMin, DMin, DMin);
    drain();
    set_bond(sbef_pkg::KindFeneWca, 32'h0001_0000, 0, 48'd1, 32'hFFFF_FFFF, '1);
    send_bond(0, 0, 0);
    send_bond(256, 0, 0);
    send_bond(257, 0, 0);
    send_bond(1, 0, 0);
    drain();
    set_bond(sbef_pkg::KindFeneWca, 32'h0001_0000, 0, 48'h1_0000, 0, 48'h1_0000);
    send_bond(32'h100, 0, 0);
    send_bond(0, 32'hFFFF_FF00, 0);
    drain();

    for (int p = 0; p < 11; p++) begin
      e = $urandom_range(2, 31);
      hk = $urandom >> $urandom_range(0, 31);
      set_bond(2'(p % 3), hk, 31'(scaled_sq(e, 0, 3) << 8),
               scaled_sq(e, 1, 6), $urandom_range(0, 3) ? $urandom : 0, scaled_sq(e, 0, 3));
      for (int i = 0; i < 50; i++) send_bond(rand_comp(e), rand_comp(e), rand_comp(e));
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.pending_q.size() != 0) report("results missing", 64'(sb.pending_q.size()), 64'd0);
    $display("checked %0d bond results over %0d register settings", n_results, n_phases);
    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sbef_pkg.sv
hdl/stretch_bond_energy_force_unit.sv
sim/tb.sv
